FILE: src/gbhs_pkg.sv
package gbhs_pkg;

    localparam int unsigned CountBits = 7;

    typedef enum logic {
        FUNC_WRITE = 1'b0,
        FUNC_QUERY = 1'b1
    } t_func;

    typedef enum logic {
        REG_ROW_COUNT    = 1'b0,
        REG_COLUMN_COUNT = 1'b1
    } t_reg_index;

endpackage

FILE: src/gbhs_store.sv
module gbhs_store #(
    parameter int unsigned DEPTH      = 4096,
    parameter int unsigned ADDR_BITS  = 12,
    parameter int unsigned DATA_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [DATA_BITS-1:0] i_wr_data,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [DATA_BITS-1:0] o_rd_data
);
    logic [DATA_BITS-1:0] r_mem [DEPTH];
    logic [DATA_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: src/gbhs_divider.sv
module gbhs_divider #(
    parameter int unsigned NUM_BITS = 64,
    parameter int unsigned DEN_BITS = 35
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic                i_neg,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quot
);
    localparam int unsigned CntBits = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] r_quot, n_quot;
    logic [DEN_BITS:0]   r_rem, n_rem;
    logic [DEN_BITS-1:0] r_den;
    logic                r_neg;
    logic [CntBits-1:0]  r_cnt;
    logic                r_busy, r_done;
    logic [DEN_BITS:0]   w_shift;

    // One quotient bit per cycle, restoring.
    always_comb begin
        w_shift = {r_rem[DEN_BITS-1:0], r_quot[NUM_BITS-1]};
        n_quot  = {r_quot[NUM_BITS-2:0], 1'b0};
        n_rem   = w_shift;
        if (w_shift >= {1'b0, r_den}) begin
            n_rem     = w_shift - {1'b0, r_den};
            n_quot[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntBits'(NUM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntBits'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
            r_neg  <= i_neg;
        end else if (r_busy) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (~r_quot + 1'b1) : r_quot;
endmodule

FILE: src/grid_bilinear_height_sampler_core.sv
// A write request stores one height in a grid memory that has a single read port. It is
// accepted without leaving the idle state, so writes can follow back to back. A query
// request works in steps: it scales the coordinates, then reads the four corners one
// after another while multiplying and accumulating, then checks the weight sum. Last, a
// restoring divider that yields one quotient bit per cycle divides the weighted sum by
// the weight sum. A query whose weight sum is zero skips the divider and answers with a
// zero height marked as not covered. One request is in work at a time. A result that
// waits for the consumer blocks new requests until it is taken, but a request can enter
// in the same cycle as the result is taken.
module grid_bilinear_height_sampler_core
    import gbhs_pkg::*;
#(
    parameter int unsigned MAX_ROWS      = 64,
    parameter int unsigned MAX_COLUMNS   = 64,
    parameter int unsigned HEIGHT_BITS   = 16,
    parameter int unsigned FRACTION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [gbhs_pkg::CountBits-1:0] i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_func,
    input  logic [5:0]                    i_row,
    input  logic [5:0]                    i_column,
    input  logic signed [HEIGHT_BITS-1:0] i_height_in,
    input  logic [FRACTION_BITS:0]        i_norm_x,
    input  logic [FRACTION_BITS:0]        i_norm_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [HEIGHT_BITS-1:0] o_height_out,
    output logic                          o_covered
);
    localparam int unsigned Depth     = MAX_ROWS * MAX_COLUMNS;
    localparam int unsigned AddrBits  = $clog2(Depth);
    localparam int unsigned CoordBits = FRACTION_BITS + 1;
    localparam int unsigned WBits     = 2 * FRACTION_BITS + 1;
    localparam int unsigned WsBits    = WBits + 2;
    localparam int unsigned AccBits   = HEIGHT_BITS + WBits + 2;
    localparam int unsigned PBits     = CoordBits + CountBits;
    localparam int unsigned IdxBits   = PBits - FRACTION_BITS + 1;
    localparam logic [WBits-1:0] One  = WBits'(1) << FRACTION_BITS;

    typedef enum logic [2:0] {
        S_IDLE, S_SCALE, S_READ, S_DIV_START, S_DIV_WAIT
    } t_state;

    t_state r_state;
    logic [CountBits-1:0] r_rows, r_cols;
    logic [CountBits-1:0] w_rows, w_cols;
    logic [PBits-1:0]     r_px, r_pz;
    logic [2:0]           r_corner;
    logic [IdxBits-1:0]   w_r, w_c;
    logic [WBits-1:0]     w_fr, w_fc, w_ar, w_ac, w_wr, w_wc;
    logic [WBits-1:0]     r_w;
    logic                 r_use;
    logic [AddrBits-1:0]  w_rd_addr, w_wr_addr;
    logic [HEIGHT_BITS-1:0] w_rd_data;
    logic signed [AccBits-1:0] r_acc;
    logic [WsBits-1:0]    r_wsum;
    logic                 w_wr_en, w_corner_ok;
    logic [2*WBits-1:0]   w_wprod;
    logic                 w_div_start, w_div_done;
    logic [AccBits-1:0]   w_quot;
    logic [AccBits-1:0]   w_abs;
    logic                 r_ovalid, r_covered;
    logic [HEIGHT_BITS-1:0] r_hout;
    logic signed [AccBits-1:0] w_prod;

    assign w_rows = (r_rows > CountBits'(MAX_ROWS > 127 ? 127 : MAX_ROWS))
                  ? CountBits'(MAX_ROWS > 127 ? 127 : MAX_ROWS) : r_rows;
    assign w_cols = (r_cols > CountBits'(MAX_COLUMNS > 127 ? 127 : MAX_COLUMNS))
                  ? CountBits'(MAX_COLUMNS > 127 ? 127 : MAX_COLUMNS) : r_cols;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= CountBits'(64);
            r_cols <= CountBits'(64);
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_ROW_COUNT) r_rows <= i_cfg_data;
            else r_cols <= i_cfg_data;
        end
    end

    // Corner order: base, row+1, both, column+1.
    always_comb begin
        w_fr = WBits'(r_px[FRACTION_BITS-1:0]);
        w_fc = WBits'(r_pz[FRACTION_BITS-1:0]);
        w_ar = One - w_fr;
        w_ac = One - w_fc;
        w_r  = IdxBits'(r_px >> FRACTION_BITS);
        w_c  = IdxBits'(r_pz >> FRACTION_BITS);
        w_wr = w_ar;
        w_wc = w_ac;
        case (r_corner[1:0])
            2'd0: begin end
            2'd1: begin w_r = w_r + 1'b1; w_wr = w_fr; end
            2'd2: begin w_r = w_r + 1'b1; w_c = w_c + 1'b1; w_wr = w_fr; w_wc = w_fc; end
            default: begin w_c = w_c + 1'b1; w_wc = w_fc; end
        endcase
        w_wprod = w_wr * w_wc;
        w_corner_ok = (w_wprod != '0) && (w_r < IdxBits'(w_rows))
                   && (w_c < IdxBits'(w_cols));
        w_rd_addr = AddrBits'(w_c + w_r * IdxBits'(w_cols));
    end

    assign w_wr_en   = i_valid && o_ready && (i_func == FUNC_WRITE)
                     && ({1'b0, i_row} < CountBits'(w_rows))
                     && ({1'b0, i_column} < CountBits'(w_cols));
    assign w_wr_addr = AddrBits'(i_column + i_row * w_cols);

    gbhs_store #(.DEPTH(Depth), .ADDR_BITS(AddrBits), .DATA_BITS(HEIGHT_BITS)) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (w_wr_en),
        .i_wr_addr(w_wr_addr),
        .i_wr_data(i_height_in),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    assign w_prod = AccBits'($signed(w_rd_data)) * $signed({1'b0, r_w});

    assign o_ready = (r_state == S_IDLE) && !(r_ovalid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready && i_func == FUNC_QUERY) begin
                        r_state <= S_SCALE;
                    end
                end
                S_SCALE: begin
                    r_state  <= S_READ;
                    r_corner <= '0;
                    r_use    <= 1'b0;
                    r_acc    <= '0;
                    r_wsum   <= '0;
                end
                S_READ: begin
                    // Address issued this cycle; data of the previous corner arrives.
                    if (r_use) begin
                        r_acc  <= r_acc + w_prod;
                        r_wsum <= r_wsum + WsBits'(r_w);
                    end
                    r_use    <= w_corner_ok && !r_corner[2];
                    r_w      <= WBits'(w_wprod);
                    r_corner <= r_corner + 1'b1;
                    if (r_corner[2]) r_state <= S_DIV_START;
                end
                S_DIV_START: begin
                    if (r_wsum == '0) begin
                        r_hout    <= '0;
                        r_covered <= 1'b0;
                        r_ovalid  <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        r_state <= S_DIV_WAIT;
                    end
                end
                S_DIV_WAIT: begin
                    if (w_div_done) begin
                        r_hout    <= HEIGHT_BITS'(w_quot);
                        r_covered <= 1'b1;
                        r_ovalid  <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_px <= PBits'(i_norm_x) * PBits'(w_rows);
            r_pz <= PBits'(i_norm_z) * PBits'(w_cols);
        end
    end

    assign w_div_start = (r_state == S_DIV_START) && (r_wsum != '0);
    assign w_abs = r_acc[AccBits-1] ? AccBits'(-r_acc) : AccBits'(r_acc);

    gbhs_divider #(.NUM_BITS(AccBits), .DEN_BITS(WsBits)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_div_start),
        .i_num  (w_abs),
        .i_neg  (r_acc[AccBits-1]),
        .i_den  (r_wsum),
        .o_done (w_div_done),
        .o_quot (w_quot)
    );

    assign o_valid      = r_ovalid;
    assign o_height_out = r_hout;
    assign o_covered    = r_covered;
endmodule

FILE: src/gbhs_checker.sv
module gbhs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic o_covered,
    input logic [15:0] o_height_out
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_height_out) && $stable(o_covered))
        else $error("result changed while stalled");
    a_uncovered_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_covered |-> o_height_out == 16'd0)
        else $error("uncovered result not zero");
    a_no_accept_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready)
        else $error("request accepted while result stalled");
endmodule

bind grid_bilinear_height_sampler_core gbhs_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_covered   (o_covered),
    .o_height_out(o_height_out)
);
